@@ sv/mpk_pkg.sv @@
// ----------------------------------------------------------------------------
// mpk_pkg: shared types and constants of the Morse pattern keyer
// Pattern store geometry, symbol codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package mpk_pkg;

   localparam int unsigned PATTERN_DEPTH = 32;
   localparam int unsigned IDX_W         = $clog2(PATTERN_DEPTH + 1);
   localparam int unsigned ADDR_W        = $clog2(PATTERN_DEPTH);
   localparam int unsigned SYM_W         = 3;
   localparam int unsigned CSR_IDX_W     = 3;

   typedef logic [SYM_W-1:0]     symbol_type;
   typedef logic [CSR_IDX_W-1:0] csr_index_type;
   typedef logic [ADDR_W-1:0]    addr_type;
   typedef logic [IDX_W-1:0]     index_type;

   localparam symbol_type SYM_DOT    = 3'd0;
   localparam symbol_type SYM_DASH   = 3'd1;
   localparam symbol_type SYM_SPACE  = 3'd2;
   localparam symbol_type SYM_REPEAT = 3'd3;

   localparam csr_index_type CSR_TICK_PRESCALE = 3'd0;
   localparam csr_index_type CSR_DOT_LENGTH    = 3'd1;
   localparam csr_index_type CSR_DASH_LENGTH   = 3'd2;
   localparam csr_index_type CSR_ELEM_GAP      = 3'd3;
   localparam csr_index_type CSR_CHAR_GAP      = 3'd4;

   localparam logic [15:0] RST_TICK_PRESCALE = 16'd5000;
   localparam logic [7:0]  RST_DOT_LENGTH    = 8'd2;
   localparam logic [7:0]  RST_DASH_LENGTH   = 8'd6;
   localparam logic [7:0]  RST_ELEM_GAP      = 8'd2;
   localparam logic [7:0]  RST_CHAR_GAP      = 8'd6;

   typedef struct packed {
      logic       en;
      addr_type   addr;
      symbol_type data;
   } store_wr_type;

endpackage

@@ sv/mpk_pattern_store.sv @@
// ----------------------------------------------------------------------------
// mpk_pattern_store: pattern symbol memory
// One write and one registered read per cycle; a write to the entry being
// read in the same cycle is forwarded to the read data.
// ----------------------------------------------------------------------------
module mpk_pattern_store
   import mpk_pkg::*;
(
   input  logic         clock,
   input  store_wr_type wr,
   input  addr_type     rd_addr,
   output symbol_type   rd_data
);

   symbol_type mem [PATTERN_DEPTH];
   symbol_type rd_raw_ff;
   symbol_type fwd_data_ff;
   logic       fwd_hit_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rd_raw_ff   <= mem[rd_addr];
      fwd_hit_ff  <= wr.en && (wr.addr == rd_addr);
      fwd_data_ff <= wr.data;
   end

   assign rd_data = fwd_hit_ff ? fwd_data_ff : rd_raw_ff;

endmodule

@@ sv/morse_pattern_keyer.sv @@
// ----------------------------------------------------------------------------
// morse_pattern_keyer: tick-driven Morse keyer playing a stored pattern
// Result: an accepted request's result is registered in the result register, or in the skid stage while stalled.
// Throughput: one request per cycle while the skid stage is empty; the store keeps the symbol at the next
// read index prefetched in its registered read port, so a step never waits.
// Reset: synchronous, active high; clears control state and loads register
// defaults. Pattern store entries stay undefined until loaded.
// ----------------------------------------------------------------------------
module morse_pattern_keyer
   import mpk_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic          req_kind,
   input  symbol_type    req_symbol,
   input  logic          req_last_symbol,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output logic          rsp_tone_on,
   output logic          rsp_sending,
   input  logic          csr_valid,
   output logic          csr_ready,
   input  csr_index_type csr_index,
   input  logic [15:0]   csr_data
);

   // configuration
   logic [15:0] tick_prescale_ff;
   logic [7:0]  dot_length_ff, dash_length_ff, elem_gap_ff, char_gap_ff;

   // keyer state
   logic [15:0] prescale_ff, prescale_in;
   logic [7:0]  period_count_ff, period_count_in;
   logic [7:0]  period_limit_ff, period_limit_in;
   logic        period_done_ff, period_done_in;
   logic        elem_pend_ff, elem_pend_in;
   logic        char_pend_ff, char_pend_in;
   logic        rep_pend_ff, rep_pend_in;
   index_type   read_index_ff, read_index_in;
   index_type   write_index_ff, write_index_in;
   index_type   pattern_len_ff, pattern_len_in;
   logic        tone_ff, tone_in;
   logic        sending_ff, sending_in;

   // result register and skid stage
   logic rsp_valid_ff, rsp_tone_ff, rsp_sending_ff;
   logic skid_valid_ff, skid_tone_ff, skid_sending_ff;

   logic         req_accept, rsp_take, step;
   logic [7:0]   count_next;
   store_wr_type store_wr;
   symbol_type   cur_sym;

   assign req_ready  = !skid_valid_ff;
   assign req_accept = req_valid && req_ready;
   assign rsp_take   = rsp_valid_ff && rsp_ready;
   assign csr_ready  = 1'b1;
   assign count_next = period_count_ff + 8'd1;

   mpk_pattern_store u_store (
      .clock   (clock),
      .wr      (store_wr),
      .rd_addr (read_index_in[ADDR_W-1:0]),
      .rd_data (cur_sym)
   );

   always_comb begin
      prescale_in     = prescale_ff;
      period_count_in = period_count_ff;
      period_limit_in = period_limit_ff;
      period_done_in  = period_done_ff;
      elem_pend_in    = elem_pend_ff;
      char_pend_in    = char_pend_ff;
      rep_pend_in     = rep_pend_ff;
      read_index_in   = read_index_ff;
      write_index_in  = write_index_ff;
      pattern_len_in  = pattern_len_ff;
      tone_in         = tone_ff;
      sending_in      = sending_ff;
      store_wr        = '0;
      step            = 1'b0;

      if (req_accept) begin
         if (req_kind) begin
            if (write_index_ff < index_type'(PATTERN_DEPTH)) begin
               store_wr.en    = 1'b1;
               store_wr.addr  = write_index_ff[ADDR_W-1:0];
               store_wr.data  = req_symbol;
               write_index_in = write_index_ff + index_type'(1);
            end
            if (req_last_symbol) begin
               pattern_len_in = write_index_in;
               write_index_in = '0;
               read_index_in  = '0;
               period_done_in = 1'b1;
            end
         end else if (prescale_ff == 16'd1) begin
            prescale_in = tick_prescale_ff;
            step        = 1'b1;
         end else begin
            prescale_in = prescale_ff - 16'd1;
         end
      end

      if (step) begin
         if (!period_done_ff && period_count_ff != 8'd0) begin
            // count the running period, drop the tone at its end
            period_count_in = count_next;
            if (count_next >= period_limit_ff) begin
               period_count_in = 8'd0;
               tone_in         = 1'b0;
               period_done_in  = 1'b1;
            end
         end else if (!period_done_ff) begin
            // idle: hold
         end else if (char_pend_ff) begin
            char_pend_in    = 1'b0;
            period_limit_in = char_gap_ff;
            period_count_in = 8'd1;
            period_done_in  = 1'b0;
            tone_in         = 1'b0;
         end else if (elem_pend_ff) begin
            elem_pend_in    = 1'b0;
            period_limit_in = elem_gap_ff;
            period_count_in = 8'd1;
            period_done_in  = 1'b0;
            tone_in         = 1'b0;
         end else if (rep_pend_ff) begin
            rep_pend_in   = 1'b0;
            read_index_in = '0;
         end else if (read_index_ff < pattern_len_ff) begin
            case (cur_sym)
               SYM_DOT, SYM_DASH: begin
                  sending_in      = 1'b1;
                  period_limit_in = (cur_sym == SYM_DOT) ? dot_length_ff : dash_length_ff;
                  period_count_in = 8'd1;
                  period_done_in  = 1'b0;
                  tone_in         = 1'b1;
                  elem_pend_in    = 1'b1;
                  read_index_in   = read_index_ff + index_type'(1);
               end
               SYM_SPACE: begin
                  sending_in    = 1'b1;
                  char_pend_in  = 1'b1;
                  read_index_in = read_index_ff + index_type'(1);
               end
               SYM_REPEAT: begin
                  // rewind on the next step
                  sending_in  = 1'b1;
                  rep_pend_in = 1'b1;
               end
               default: begin
                  sending_in = 1'b0;
               end
            endcase
         end else begin
            sending_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_prescale_ff <= RST_TICK_PRESCALE;
         dot_length_ff    <= RST_DOT_LENGTH;
         dash_length_ff   <= RST_DASH_LENGTH;
         elem_gap_ff      <= RST_ELEM_GAP;
         char_gap_ff      <= RST_CHAR_GAP;
         prescale_ff      <= 16'd1;
         period_count_ff  <= '0;
         period_limit_ff  <= '0;
         period_done_ff   <= 1'b0;
         elem_pend_ff     <= 1'b0;
         char_pend_ff     <= 1'b0;
         rep_pend_ff      <= 1'b0;
         read_index_ff    <= '0;
         write_index_ff   <= '0;
         pattern_len_ff   <= '0;
         tone_ff          <= 1'b0;
         sending_ff       <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         skid_valid_ff    <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_TICK_PRESCALE: tick_prescale_ff <= csr_data;
               CSR_DOT_LENGTH:    dot_length_ff    <= csr_data[7:0];
               CSR_DASH_LENGTH:   dash_length_ff   <= csr_data[7:0];
               CSR_ELEM_GAP:      elem_gap_ff      <= csr_data[7:0];
               CSR_CHAR_GAP:      char_gap_ff      <= csr_data[7:0];
               default: ;
            endcase
         end
         prescale_ff     <= prescale_in;
         period_count_ff <= period_count_in;
         period_limit_ff <= period_limit_in;
         period_done_ff  <= period_done_in;
         elem_pend_ff    <= elem_pend_in;
         char_pend_ff    <= char_pend_in;
         rep_pend_ff     <= rep_pend_in;
         read_index_ff   <= read_index_in;
         write_index_ff  <= write_index_in;
         pattern_len_ff  <= pattern_len_in;
         tone_ff         <= tone_in;
         sending_ff      <= sending_in;

         if (!rsp_valid_ff || rsp_take) begin
            rsp_valid_ff  <= skid_valid_ff || req_accept;
            skid_valid_ff <= 1'b0;
         end else if (req_accept) begin
            skid_valid_ff <= 1'b1;
         end
      end
   end

   // result payload: advance from the skid stage first, else take the new result
   always_ff @(posedge clock) begin
      if (!rsp_valid_ff || rsp_take) begin
         rsp_tone_ff    <= skid_valid_ff ? skid_tone_ff : tone_in;
         rsp_sending_ff <= skid_valid_ff ? skid_sending_ff : sending_in;
      end else if (req_accept) begin
         skid_tone_ff    <= tone_in;
         skid_sending_ff <= sending_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_tone_on = rsp_tone_ff;
   assign rsp_sending = rsp_sending_ff;

endmodule

@@ sv/mpk_checker.sv @@
// ----------------------------------------------------------------------------
// mpk_checker: port-level checks for the Morse pattern keyer
// Watches the request and response handshakes over time.
// ----------------------------------------------------------------------------
module mpk_checker
   import mpk_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_tone_on,
   input logic rsp_sending
);

   // no response straight out of reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_tone_on) && $stable(rsp_sending))
      else $error("stalled response changed");

   // a request taken with the output empty shows its result next cycle
   a_rsp_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !rsp_valid |=> rsp_valid)
      else $error("result did not appear one cycle after request");

   // requests back up only while a response is waiting
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("request stalled with no pending response");

endmodule

bind morse_pattern_keyer mpk_checker u_mpk_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_tone_on (rsp_tone_on),
   .rsp_sending (rsp_sending)
);
